>>> hdl/unsigned_to_decimal_ascii_top_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define U2DA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("u2da check failed");

// Check a property on every clock edge, reset included.
`define U2DA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("u2da reset check failed");

`endif

>>> hdl/u2da_pkg.sv
package u2da_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 10;
    localparam int IN_W       = 32;
    localparam int CHAR_W     = 6;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'h30;

    typedef logic [IN_W-1:0]       t_in;
    typedef logic [VALUE_BITS-1:0] t_bin;
    typedef logic [BCD_W-1:0]      t_bcd;
    typedef logic [3:0]            t_digit;
    typedef logic [CHAR_W-1:0]     t_char;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;       // capture a new value, clear the BCD register
        logic dabble;     // one double-dabble step
        logic skip;       // drop a leading zero digit
        logic emit;       // move the top digit to the output register
        logic emit_last;  // the digit being emitted ends the run
    } t_cmd;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic top_zero;   // top BCD digit is zero
        logic ovf;        // value has more than MAX_DIGITS digits
        logic out_busy;   // output register holds an untaken digit
    } t_stat;

endpackage

>>> hdl/u2da_datapath.sv
module u2da_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u2da_pkg::t_cmd  i_cmd,
    output u2da_pkg::t_stat o_stat,
    input  u2da_pkg::t_in   i_value,
    input  logic            i_stall,
    output logic            o_valid,
    output u2da_pkg::t_char o_digit_char,
    output logic            o_last_char
);
    import u2da_pkg::*;

    t_bin   r_bin;
    t_bcd   r_bcd;
    t_bcd   n_fix;
    logic   r_ovf;
    t_char  r_out_char;
    logic   r_out_last;
    logic   r_out_valid;
    t_digit top_digit;

    // Add 3 to every digit of five or more before the shift.
    always_comb begin
        n_fix = r_bcd;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_fix[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= t_bin'(i_value);
            r_bcd <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.dabble) begin
            r_bcd <= {n_fix[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= r_bin << 1;
            r_ovf <= r_ovf | n_fix[BCD_W-1];
        end else if (i_cmd.skip || i_cmd.emit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= DIGIT_BASE | t_char'(top_digit);
            r_out_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.top_zero = (top_digit == 4'd0);
    assign o_stat.ovf      = r_ovf;
    assign o_stat.out_busy = r_out_valid & i_stall;

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_char  = r_out_last;

endmodule

>>> hdl/u2da_ctrl.sv
module u2da_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  u2da_pkg::t_stat i_stat,
    output u2da_pkg::t_cmd  o_cmd
);
    import u2da_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [BIT_CNT_W-1:0] n_bit_cnt;
    logic [DIG_CNT_W-1:0] r_dig_cnt;
    logic [DIG_CNT_W-1:0] n_dig_cnt;
    logic                 dig_one;

    assign dig_one = (r_dig_cnt == DIG_CNT_W'(1));

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        o_cmd     = '0;
        o_stall   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit_cnt  = BIT_CNT_W'(VALUE_BITS - 1);
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
                if (r_bit_cnt == '0) begin
                    n_dig_cnt = DIG_CNT_W'(MAX_DIGITS);
                    n_state   = S_SKIP;
                end else begin
                    n_bit_cnt = r_bit_cnt - 1'b1;
                end
            end
            S_SKIP: begin
                // Drop leading zeros, but never the last digit.
                if (i_stat.top_zero && !dig_one && !i_stat.ovf) begin
                    o_cmd.skip = 1'b1;
                    n_dig_cnt  = r_dig_cnt - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = dig_one;
                    n_dig_cnt       = r_dig_cnt - 1'b1;
                    if (dig_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_dig_cnt <= n_dig_cnt;
        end
    end

endmodule

>>> hdl/unsigned_to_decimal_ascii_top.sv
// Unsigned binary to decimal ASCII converter. Each input transaction carries
// one unsigned number on i_value (only the low VALUE_BITS bits count); the
// block answers with one output transaction per decimal digit, most
// significant first, without leading zeros, as ASCII '0'..'9' on
// o_digit_char, and raises o_last_char on the least significant digit. Zero
// gives the single character '0'. A number with more than MAX_DIGITS digits
// yields only its low MAX_DIGITS digits. One number is loaded, goes through
// VALUE_BITS double-dabble steps (one bit per cycle through the shared
// add-3 stage), has its leading zeros dropped, leaves the zero-dropping
// step and has its digits emitted. Dropped zeros and emitted digits always
// add up to MAX_DIGITS. While a digit in the output register waits on
// i_stall, the next digit waits too. The next number is taken as soon as
// the last digit sits in the output register, even while that digit still
// waits to be taken.
module unsigned_to_decimal_ascii_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  u2da_pkg::t_in   i_value,
    output logic            o_valid,
    input  logic            i_stall,
    output u2da_pkg::t_char o_digit_char,
    output logic            o_last_char
);
    import u2da_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: load, convert, drop leading zeros, emit digits.
    u2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Shift register, BCD register and output register.
    u2da_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_value      (i_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_char  (o_last_char)
    );

endmodule

>>> hdl/u2da_checker.sv
`include "unsigned_to_decimal_ascii_top_macros.svh"

module u2da_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input u2da_pkg::t_char o_digit_char,
    input logic            o_last_char
);
    import u2da_pkg::*;

    // Every presented character is a decimal digit.
    `U2DA_ASSERT(a_digit_range, o_valid |-> (o_digit_char >= 6'h30 && o_digit_char <= 6'h39))

    // A new number is accepted only when the previous run has fully ended.
    `U2DA_ASSERT(a_accept_after_last, (i_valid && !o_stall && o_valid) |-> o_last_char)

    // After accepting a number the input side holds off while converting.
    `U2DA_ASSERT(a_busy_after_accept, (i_valid && !o_stall) |=> o_stall)

    // A stalled output transaction holds.
    `U2DA_ASSERT(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_digit_char) && $stable(o_last_char)))

    // Reset leaves nothing on the output.
    `U2DA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)

endmodule

bind unsigned_to_decimal_ascii_top u2da_checker u_u2da_checker (.*);
